// ----- src/sas_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sas_pkg
// Shared types and constants for the struct array serialiser.
// ---------------------------------------------------------------------------
package sas_pkg;

    // item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRUCT_COUNT  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_COUNT   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_TYPES   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LITTLE_ENDIAN = 8'd3;
    localparam int unsigned CFG_DATA_W = 64;

    // job: up to two header bytes plus eight type bytes
    localparam int unsigned JOB_BYTES  = 10;
    localparam int unsigned JOB_CNT_W  = 4;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } sas_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } sas_out_t;

    // bytes are sent from index 0 upwards, count is at least one
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [JOB_CNT_W-1:0]      count;
    } sas_job_t;

endpackage

// ----- src/sas_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sas_fifo
// Short flop-based job queue between the front and back parts.
// ---------------------------------------------------------------------------
module sas_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  sas_pkg::sas_job_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output sas_pkg::sas_job_t pop_data
);
    import sas_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sas_job_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/sas_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sas_front
// Configuration registers, struct position tracking and job building.
// ---------------------------------------------------------------------------
module sas_front #(
    parameter int unsigned MAX_FIELDS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sas_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  sas_pkg::sas_in_t                 item,
    output logic                             job_valid,
    input  logic                             job_ready,
    output sas_pkg::sas_job_t                job
);
    import sas_pkg::*;

    // configuration
    logic [7:0]  struct_count_reg;
    logic [5:0]  field_count_reg;
    logic [63:0] field_types_reg;
    logic        little_endian_reg;

    // walk state
    logic [8:0]  struct_offset_reg, struct_offset_next;
    logic [5:0]  field_position_reg, field_position_next;
    logic [2:0]  byte_in_field_reg, byte_in_field_next;
    logic [7:0]  structs_done_reg, structs_done_next;
    logic [7:0]  swap_buffer_reg [8];

    logic        accept;
    logic        has_job;
    logic        buf_write;
    logic [5:0]  n_eff;
    logic        active;
    logic [1:0]  cur_type;
    logic [2:0]  size_mask;
    logic [2:0]  struct_mask;
    logic        any1, any2, any3;
    logic        skipped;
    logic [7:0]  buf_view [8];
    logic [3:0]  nb;
    logic [7:0]  type_byte;

    assign cfg_ready  = 1'b1;
    assign item_ready = job_ready;
    assign accept     = item_valid && item_ready;
    assign job_valid  = item_valid && has_job;

    // effective field count, saturated
    assign n_eff  = (field_count_reg > 6'(MAX_FIELDS)) ? 6'(MAX_FIELDS) : field_count_reg;
    assign active = (n_eff != '0) && (structs_done_reg < struct_count_reg);

    // widest field type of the struct
    always_comb
    begin
        any1 = 1'b0;
        any2 = 1'b0;
        any3 = 1'b0;
        for (int j = 0; j < 32; j++)
        begin
            if (6'(j) < n_eff)
            begin
                any1 = any1 | (field_types_reg[2*j +: 2] == 2'd1);
                any2 = any2 | (field_types_reg[2*j +: 2] == 2'd2);
                any3 = any3 | (field_types_reg[2*j +: 2] == 2'd3);
            end
        end
        struct_mask = any3 ? 3'b111 : (any2 ? 3'b011 : (any1 ? 3'b001 : 3'b000));
    end

    // size of the current field as an alignment mask
    assign cur_type = field_types_reg[{field_position_reg[4:0], 1'b0} +: 2];
    always_comb
    begin
        case (cur_type)
            2'd0:    size_mask = 3'b000;
            2'd1:    size_mask = 3'b001;
            2'd2:    size_mask = 3'b011;
            default: size_mask = 3'b111;
        endcase
    end

    // swap buffer as it stands with the incoming byte
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            buf_view[i] = (3'(i) == byte_in_field_reg) ? item.data_byte : swap_buffer_reg[i];
        end
    end

    // classify the item, build the job and the next walk state
    always_comb
    begin
        struct_offset_next  = struct_offset_reg;
        field_position_next = field_position_reg;
        byte_in_field_next  = byte_in_field_reg;
        structs_done_next   = structs_done_reg;
        has_job   = 1'b0;
        buf_write = 1'b0;
        skipped   = 1'b0;
        job       = '0;
        nb        = 4'(({1'b0, n_eff} + 7'd3) >> 2);
        type_byte = '0;
        if (item.func == FUNC_START)
        begin
            // header transfer
            struct_offset_next  = '0;
            field_position_next = '0;
            byte_in_field_next  = '0;
            structs_done_next   = '0;
            has_job      = 1'b1;
            job.bytes[0] = struct_count_reg;
            job.bytes[1] = {little_endian_reg, 1'b0, n_eff};
            for (int j = 0; j < 8; j++)
            begin
                type_byte = '0;
                for (int k = 0; k < 4; k++)
                begin
                    if (6'(4*j + k) < n_eff)
                    begin
                        type_byte[2*(3-k) +: 2] = field_types_reg[2*(4*j + k) +: 2];
                    end
                end
                job.bytes[2 + j] = type_byte;
            end
            job.count = nb + 4'd2;
        end
        else if (active)
        begin
            if (field_position_reg < n_eff)
            begin
                if ((byte_in_field_reg == '0) &&
                    ((struct_offset_reg[2:0] & size_mask) != '0))
                begin
                    // alignment padding before the field
                    struct_offset_next = struct_offset_reg + 1'b1;
                    skipped = 1'b1;
                end
                else
                begin
                    buf_write = 1'b1;
                    struct_offset_next = struct_offset_reg + 1'b1;
                    if (little_endian_reg)
                    begin
                        has_job      = 1'b1;
                        job.bytes[0] = item.data_byte;
                        job.count    = 4'd1;
                    end
                    if (byte_in_field_reg >= size_mask)
                    begin
                        // field complete: big endian sends it reversed
                        if (!little_endian_reg)
                        begin
                            has_job = 1'b1;
                            for (int i = 0; i < 8; i++)
                            begin
                                if (3'(i) <= byte_in_field_reg)
                                begin
                                    job.bytes[i] = buf_view[byte_in_field_reg - 3'(i)];
                                end
                            end
                            job.count = {1'b0, byte_in_field_reg} + 4'd1;
                        end
                        byte_in_field_next  = '0;
                        field_position_next = field_position_reg + 1'b1;
                    end
                    else
                    begin
                        byte_in_field_next = byte_in_field_reg + 1'b1;
                    end
                end
            end
            else
            begin
                // trailing struct padding
                struct_offset_next = struct_offset_reg + 1'b1;
            end
            if (!skipped && (field_position_next >= n_eff) &&
                ((struct_offset_next[2:0] & struct_mask) == '0))
            begin
                struct_offset_next  = '0;
                field_position_next = '0;
                byte_in_field_next  = '0;
                structs_done_next   = structs_done_reg + 1'b1;
            end
        end
    end

    // configuration and walk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            struct_count_reg   <= '0;
            field_count_reg    <= 6'd1;
            field_types_reg    <= '0;
            little_endian_reg  <= 1'b0;
            struct_offset_reg  <= '0;
            field_position_reg <= '0;
            byte_in_field_reg  <= '0;
            structs_done_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_STRUCT_COUNT:  struct_count_reg  <= cfg_data[7:0];
                    CFG_FIELD_COUNT:   field_count_reg   <= cfg_data[5:0];
                    CFG_FIELD_TYPES:   field_types_reg   <= cfg_data;
                    CFG_LITTLE_ENDIAN: little_endian_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                struct_offset_reg  <= struct_offset_next;
                field_position_reg <= field_position_next;
                byte_in_field_reg  <= byte_in_field_next;
                structs_done_reg   <= structs_done_next;
            end
        end
    end

    // field byte buffer
    always_ff @(posedge clk)
    begin
        if (accept && buf_write)
        begin
            swap_buffer_reg[byte_in_field_reg] <= item.data_byte;
        end
    end

endmodule

// ----- src/sas_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sas_back
// Walks the head job byte by byte into the registered result port.
// ---------------------------------------------------------------------------
module sas_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  sas_pkg::sas_job_t job,
    output logic              result_valid,
    input  logic              result_ready,
    output sas_pkg::sas_out_t result
);
    import sas_pkg::*;

    logic [JOB_CNT_W-1:0] index_reg, index_next;
    logic                 valid_reg;
    sas_out_t             result_reg;
    logic                 load;
    logic                 final_byte;

    assign result_valid = valid_reg;
    assign result       = result_reg;
    assign load         = job_valid && (!valid_reg || result_ready);
    assign final_byte   = (index_reg == job.count - 4'd1);
    assign job_ready    = load && final_byte;
    assign index_next   = final_byte ? '0 : index_reg + 1'b1;

    // control: byte index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                index_reg <= index_next;
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.out_byte <= job.bytes[index_reg];
            result_reg.last     <= final_byte;
        end
    end

endmodule

// ----- src/struct_array_serializer_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// struct_array_serializer_core
// Serialises a byte stream of aligned structs into a packed header plus data.
// ---------------------------------------------------------------------------
// Usage:
//   cfg channel: register writes (index, data), always ready; write only
//   while the block is idle.
//   item channel: func start emits the header (struct count, field count
//   with bit 7 for little endian, packed type codes); func data carries one
//   source byte, padding included.
//   result channel: one byte per transfer, last marks the final byte caused
//   by one item.
// Path: an item's job is written into the job queue, then loaded into the
//   result register, from which the first byte can transfer.
// Throughput: one item per cycle while the four-entry job queue has room;
//   the result port sends one byte per cycle while the receiver is ready;
//   a header is two to ten bytes and a big-endian field flush one to eight.
// Reset: position, struct counter and queue clear; registers take their
//   reset values (one field, byte types, big endian, zero structs).
// A stalled receiver holds the result register; the queue then fills and
//   item_ready drops until bytes drain.
// ---------------------------------------------------------------------------
module struct_array_serializer_core #(
    parameter int unsigned MAX_FIELDS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sas_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  sas_pkg::sas_in_t                 item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output sas_pkg::sas_out_t                result
);
    import sas_pkg::*;

    logic     push_valid, push_ready;
    sas_job_t push_job;
    logic     pop_valid, pop_ready;
    sas_job_t pop_job;

    // front: config, position tracking, job building
    sas_front #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_valid  (push_valid),
        .job_ready  (push_ready),
        .job        (push_job)
    );

    // job queue
    sas_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    // back: byte sequencing to the result port
    sas_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (pop_valid),
        .job_ready    (pop_ready),
        .job          (pop_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- tb/struct_array_serializer_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// struct_array_serializer_core_tb
// Self-checking bench for the struct array serialiser. A shadow model of the
// registers and the struct position predicts every output byte for each
// accepted start or data transfer. A checker compares each result transfer
// against the oldest predicted byte. Directed tests cover header forms, field
// widths, byte reversal, ignored data and reconfiguration mid-struct. A
// random part then streams well-formed struct arrays with broken and stray
// sequences mixed in, with random gaps on both channels.
// ---------------------------------------------------------------------------
module struct_array_serializer_core_tb;
    import sas_pkg::*;

    localparam int unsigned MAX_FIELDS   = 32;
    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned RESET_CYCLES = 5;
    // queue depth plus pipeline, with margin
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 120;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    sas_in_t                item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    sas_out_t               result;

    // shadow registers
    logic [7:0]  reg_struct_count;
    logic [5:0]  reg_field_count;
    logic [63:0] reg_field_types;
    logic        reg_little_endian;

    // shadow position within the struct array
    logic [8:0]  byte_offset;
    logic [5:0]  field_idx;
    logic [2:0]  field_fill;
    logic [7:0]  swap_bytes [8];
    logic [7:0]  structs_seen;

    sas_out_t    awaited_bytes [$];
    bit          quiet_link  = 1'b0;
    int unsigned failures    = 0;
    int unsigned cycle_count = 0;

    struct_array_serializer_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    initial
    begin : clock_gen
        forever #(CLK_HALF) clk = ~clk;
    end

    // cycle limit
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // gap length: mostly none, some short, a few long
    function automatic int unsigned gap_len();
        int unsigned r;
        if (quiet_link)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // fields in use, saturated at the maximum
    function automatic int unsigned active_fields();
        return (reg_field_count > MAX_FIELDS) ? MAX_FIELDS : int'(reg_field_count);
    endfunction

    function automatic int unsigned field_size(input int unsigned j);
        return 1 << reg_field_types[2*j +: 2];
    endfunction

    function automatic void clear_position();
        byte_offset = '0;
        field_idx   = '0;
        field_fill  = '0;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        sas_out_t r;
        r.out_byte = b;
        r.last     = 1'b0;
        awaited_bytes.push_back(r);
    endfunction

    // predicted output bytes for one accepted transfer
    function automatic void serialise_item(input sas_in_t it);
        int unsigned n;
        int unsigned widest;
        int unsigned span;
        int unsigned base;
        int unsigned j;
        int unsigned k;
        int          m;
        logic [7:0]  hdr;
        sas_out_t    tail;
        n    = active_fields();
        base = awaited_bytes.size();
        if (it.func == FUNC_START)
        begin
            // header: count, field count with endian flag, packed type codes
            clear_position();
            structs_seen = '0;
            push_byte(reg_struct_count);
            push_byte({reg_little_endian, 7'(n)});
            for (j = 0; j < (n + 3) / 4; j++)
            begin
                hdr = '0;
                for (k = 0; k < 4; k++)
                    if (4*j + k < n)
                        hdr[2*(3-k) +: 2] = reg_field_types[2*(4*j + k) +: 2];
                push_byte(hdr);
            end
        end
        else if (n != 0 && structs_seen < reg_struct_count)
        begin
            widest = 1;
            for (j = 0; j < n; j++)
                if (field_size(j) > widest)
                    widest = field_size(j);
            if (field_idx < n)
            begin
                span = field_size(field_idx);
                // alignment padding ahead of a field
                if (field_fill == 0 && byte_offset % span != 0)
                begin
                    byte_offset++;
                    return;
                end
                swap_bytes[field_fill] = it.data_byte;
                if (reg_little_endian)
                    push_byte(it.data_byte);
                byte_offset++;
                if (field_fill + 1 >= span)
                begin
                    // field complete, big endian flushes reversed
                    if (!reg_little_endian)
                        for (m = int'(field_fill); m >= 0; m--)
                            push_byte(swap_bytes[m]);
                    field_fill = '0;
                    field_idx++;
                end
                else
                    field_fill++;
            end
            else
                byte_offset++;
            // end of struct once aligned to the widest field
            if (field_idx >= n && byte_offset % widest == 0)
            begin
                clear_position();
                structs_seen++;
            end
        end
        if (awaited_bytes.size() > base)
        begin
            tail      = awaited_bytes.pop_back();
            tail.last = 1'b1;
            awaited_bytes.push_back(tail);
        end
    endfunction

    // one item transfer, valid held until accepted
    task automatic send_item(input logic f, input logic [7:0] b);
        int unsigned gap;
        sas_in_t     it;
        gap          = gap_len();
        it.func      = f;
        it.data_byte = b;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        serialise_item(it);
    endtask

    // stop sending until every predicted byte has arrived
    task automatic hold_items();
        item_valid <= 1'b0;
        do @(posedge clk); while (awaited_bytes.size() != 0);
    endtask

    task automatic settle();
        hold_items();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_STRUCT_COUNT:  reg_struct_count  = val[7:0];
            CFG_FIELD_COUNT:   reg_field_count   = val[5:0];
            CFG_FIELD_TYPES:   reg_field_types   = val;
            CFG_LITTLE_ENDIAN: reg_little_endian = val[0];
            default: ;
        endcase
    endtask

    // full register set, written only once the block is idle
    task automatic configure(input logic [7:0] sc, input logic [5:0] fc,
                             input logic [63:0] ft, input logic le);
        settle();
        write_reg(CFG_STRUCT_COUNT, 64'(sc));
        write_reg(CFG_FIELD_COUNT, 64'(fc));
        write_reg(CFG_FIELD_TYPES, ft);
        write_reg(CFG_LITTLE_ENDIAN, 64'(le));
        cfg_valid <= 1'b0;
    endtask

    // result checker and receiver stalls
    initial
    begin : result_check
        sas_out_t    want;
        int unsigned stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (awaited_bytes.size() == 0)
                begin
                    failures++;
                    $error("unexpected transfer: out_byte %h last %b",
                           result.out_byte, result.last);
                end
                else
                begin
                    want = awaited_bytes.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        failures++;
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, result.out_byte);
                    end
                    if (result.last !== want.last)
                    begin
                        failures++;
                        $error("last: expected %b, actual %b", want.last, result.last);
                    end
                end
            end
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    // data ahead of any start: dropped with zero structs, then parsed from offset zero
    task automatic test_data_before_start();
        int unsigned i;
        send_item(FUNC_DATA, 8'h3C);
        send_item(FUNC_DATA, 8'hC3);
        // half then byte, little endian, one struct of four bytes
        configure(8'd1, 6'd2, 64'h1, 1'b1);
        for (i = 0; i < 4; i++)
            send_item(FUNC_DATA, 8'(8'h10 + i));
    endtask

    // header forms at the register extremes
    task automatic test_header_forms();
        configure(8'd0, 6'd0, 64'h0, 1'b0);
        send_item(FUNC_START, 8'h00);
        // no fields: data dropped
        configure(8'd4, 6'd0, 64'h0, 1'b0);
        send_item(FUNC_START, 8'hFF);
        send_item(FUNC_DATA, 8'hFF);
        configure(8'd255, 6'd32, '1, 1'b1);
        send_item(FUNC_START, 8'h5A);
        // field count above the maximum saturates
        configure(8'hA5, 6'd63, 64'h0123_4567_89AB_CDEF, 1'b0);
        send_item(FUNC_START, 8'hA5);
        configure(8'd3, 6'd5, 64'h2D3, 1'b1);
        send_item(FUNC_START, 8'h00);
    endtask

    // every field width in big endian, with a pause mid-struct
    task automatic test_field_widths();
        logic [7:0]  src [16];
        int unsigned i;
        src = '{8'h00, 8'hFF, 8'h12, 8'h34, 8'h80, 8'h7F, 8'h01, 8'hFE,
                8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88};
        // byte, half, word, double
        configure(8'd1, 6'd4, 64'hE4, 1'b0);
        send_item(FUNC_START, 8'h00);
        for (i = 0; i < 16; i++)
        begin
            send_item(FUNC_DATA, src[i]);
            if (i == 7)
                hold_items();
        end
        // past the struct count: dropped
        send_item(FUNC_DATA, 8'hAA);
    endtask

    // register changes between transfers of one struct
    task automatic test_midstream_reconfig();
        configure(8'd2, 6'd2, 64'hA, 1'b0);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_DATA, 8'hA1);
        send_item(FUNC_DATA, 8'hA2);
        // first field shrinks to a half while two bytes are held
        configure(8'd2, 6'd2, 64'h9, 1'b0);
        send_item(FUNC_DATA, 8'hA3);
        send_item(FUNC_DATA, 8'hA4);
        // no fields: bytes dropped, position kept
        configure(8'd2, 6'd0, 64'h9, 1'b0);
        send_item(FUNC_DATA, 8'hEE);
        send_item(FUNC_DATA, 8'h77);
        configure(8'd2, 6'd2, 64'h9, 1'b1);
        while (structs_seen == 0)
            send_item(FUNC_DATA, 8'($urandom));
        send_item(FUNC_DATA, 8'hC0);
        send_item(FUNC_DATA, 8'h0C);
        // field position now past the field count: end padding
        configure(8'd2, 6'd1, 64'h9, 1'b1);
        while (structs_seen < 8'd2)
            send_item(FUNC_DATA, 8'($urandom));
    endtask

    // random struct arrays, mostly complete, some cut short or with stray bytes
    task automatic test_random_streams();
        int unsigned sent;
        int unsigned phase;
        int unsigned pick;
        int unsigned stop_at;
        logic [7:0]  sc;
        logic [5:0]  fc;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet_link = (phase % 5 == 3);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                sc = 8'd0;
            else if (pick == 1)
                sc = 8'($urandom_range(4, 255));
            else
                sc = 8'($urandom_range(1, 2));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                fc = 6'd0;
            else if (pick < 3)
                fc = 6'($urandom_range(7, 63));
            else
                fc = 6'($urandom_range(1, 4));
            configure(sc, fc, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
            send_item(FUNC_START, 8'($urandom));
            sent++;
            if (fc > 6'd8)
                stop_at = $urandom_range(4, 24);
            else if ($urandom_range(0, 5) == 0)
                stop_at = $urandom_range(1, 12);
            else
                stop_at = 60;
            while (active_fields() != 0 && structs_seen < reg_struct_count && stop_at != 0)
            begin
                send_item(FUNC_DATA, 8'($urandom));
                sent++;
                stop_at--;
            end
            // stray bytes after the array
            repeat ($urandom_range(0, 2))
                send_item(FUNC_DATA, 8'($urandom));
            phase++;
        end
        quiet_link = 1'b0;
    endtask

    // main sequence
    initial
    begin : main_seq
        reg_struct_count  = 8'd0;
        reg_field_count   = 6'd1;
        reg_field_types   = 64'h0;
        reg_little_endian = 1'b0;
        clear_position();
        structs_seen = '0;
        foreach (swap_bytes[i])
            swap_bytes[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_data_before_start();
        test_header_forms();
        test_field_widths();
        test_midstream_reconfig();
        test_random_streams();
        settle();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
